FILE: rtl/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, constants and symbol tables for the integer to Roman numeral
// converter.
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int ValueW    = 12;
  localparam int ValueMax  = 3999;
  localparam int DigitW    = 4;
  localparam int NumPlaces = 4;
  localparam int PlaceW    = 2;
  localparam int StepW     = 2;
  localparam int LenW      = 3;
  localparam int SymW      = 8;
  localparam int InTdataW  = 16;
  localparam int OutTdataW = 8;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [SymW-1:0] ChI = 8'h49;
  localparam logic [SymW-1:0] ChV = 8'h56;
  localparam logic [SymW-1:0] ChX = 8'h58;
  localparam logic [SymW-1:0] ChL = 8'h4C;
  localparam logic [SymW-1:0] ChC = 8'h43;
  localparam logic [SymW-1:0] ChD = 8'h44;
  localparam logic [SymW-1:0] ChM = 8'h4D;
  localparam logic [SymW-1:0] ChNone = 8'h00;

  typedef struct packed {
    logic                                 invalid;
    logic [NumPlaces-1:0][DigitW-1:0]     digits;
  } irn_entry_t;

  typedef enum logic [1:0] {
    KindOne,
    KindFive,
    KindTen
  } sym_kind_e;

  // Number of characters a decimal digit produces in its place.
  function automatic logic [LenW-1:0] digit_len(logic [DigitW-1:0] d);
    logic [LenW-1:0] len;
    unique case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Character at position k within the run of one decimal place.
  function automatic logic [SymW-1:0] sym_at(logic [PlaceW-1:0] place,
                                             logic [DigitW-1:0] d,
                                             logic [StepW-1:0]  k);
    sym_kind_e       kind;
    logic [SymW-1:0] ch;
    if (d == 4'd9 && k != '0) begin
      kind = KindTen;
    end else if (d == 4'd4 && k != '0) begin
      kind = KindFive;
    end else if (d >= 4'd5 && d != 4'd9 && k == '0) begin
      kind = KindFive;
    end else begin
      kind = KindOne;
    end
    ch = ChNone;
    unique case (kind)
      KindOne: begin
        unique case (place)
          2'd0: ch = ChI;
          2'd1: ch = ChX;
          2'd2: ch = ChC;
          2'd3: ch = ChM;
        endcase
      end
      KindFive: begin
        unique case (place)
          2'd0: ch = ChV;
          2'd1: ch = ChL;
          2'd2: ch = ChD;
          2'd3: ch = ChNone;
        endcase
      end
      KindTen: begin
        unique case (place)
          2'd0: ch = ChX;
          2'd1: ch = ChC;
          2'd2: ch = ChM;
          2'd3: ch = ChNone;
        endcase
      end
      default: ch = ChNone;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/irn_front.sv
// ----------------------------------------------------------------------------
// irn_front
// Accepts a binary value, flags it when out of range and splits it into four
// decimal digits by compare and subtract, the units being the last remainder.
// ----------------------------------------------------------------------------
module irn_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [irn_pkg::ValueW-1:0] value_i,
  output logic                       entry_valid_o,
  input  logic                       entry_ready_i,
  output irn_pkg::irn_entry_t        entry_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  localparam int ProdW = irn_pkg::ValueW + 2;
  localparam int Radix = 10;

  logic [1:0]                                      state_q, state_d;
  logic [irn_pkg::PlaceW-1:0]                      place_q, place_d;
  logic [irn_pkg::ValueW-1:0]                      rem_q, rem_d;
  logic [irn_pkg::NumPlaces-1:0][irn_pkg::DigitW-1:0] dig_q, dig_d;
  logic                                            inv_q, inv_d;
  logic [Radix-1:0][ProdW-1:0]                     mult;
  logic [irn_pkg::DigitW-1:0]                      digit;
  logic [irn_pkg::ValueW-1:0]                      rem_next;

  // Multiples of the weight of the current place.
  always_comb begin
    for (int j = 0; j < Radix; j++) begin
      unique case (place_q)
        2'd3: mult[j] = ProdW'(j * 1000);
        2'd2: mult[j] = ProdW'(j * 100);
        2'd1: mult[j] = ProdW'(j * 10);
        2'd0: mult[j] = ProdW'(j);
      endcase
    end
  end

  always_comb begin
    digit = '0;
    for (int j = 1; j < Radix; j++) begin
      if (ProdW'(rem_q) >= mult[j]) begin
        digit = irn_pkg::DigitW'(j);
      end
    end
  end

  assign rem_next = rem_q - mult[digit][irn_pkg::ValueW-1:0];

  always_comb begin
    state_d = state_q;
    place_d = place_q;
    rem_d   = rem_q;
    dig_d   = dig_q;
    inv_d   = inv_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          rem_d   = value_i;
          place_d = irn_pkg::PlaceW'(irn_pkg::NumPlaces - 1);
          inv_d   = (value_i == '0) ||
                    (value_i > irn_pkg::ValueW'(irn_pkg::ValueMax));
          state_d = StConv;
        end
      end
      StConv: begin
        dig_d[place_q] = digit;
        rem_d          = rem_next;
        place_d        = place_q - 1'b1;
        if (place_q == irn_pkg::PlaceW'(1)) begin
          dig_d[0] = rem_next[irn_pkg::DigitW-1:0];
          state_d  = StHold;
        end
      end
      StHold: begin
        if (entry_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    place_q <= place_d;
    rem_q   <= rem_d;
    dig_q   <= dig_d;
    inv_q   <= inv_d;
  end

  assign in_ready_o       = (state_q == StIdle);
  assign entry_valid_o    = (state_q == StHold);
  assign entry_o.invalid  = inv_q;
  assign entry_o.digits   = dig_q;

endmodule

FILE: rtl/irn_queue.sv
// ----------------------------------------------------------------------------
// irn_queue
// Short queue of converted entries between the front and the back part.
// ----------------------------------------------------------------------------
module irn_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  irn_pkg::irn_entry_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output irn_pkg::irn_entry_t pop_data_o
);

  irn_pkg::irn_entry_t            mem_q [irn_pkg::QueueDepth];
  logic [irn_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [irn_pkg::QueueCntW-1:0]  cnt_q;
  logic                           push, pop;

  assign push_ready_o = (cnt_q != irn_pkg::QueueCntW'(irn_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == irn_pkg::QueuePtrW'(irn_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == irn_pkg::QueuePtrW'(irn_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/irn_back.sv
// ----------------------------------------------------------------------------
// irn_back
// Walks the decimal places of one entry and emits one numeral character per
// cycle into an output register, while that register is free to take it.
// ----------------------------------------------------------------------------
module irn_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     entry_valid_i,
  output logic                     entry_ready_o,
  input  irn_pkg::irn_entry_t      entry_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [irn_pkg::SymW-1:0] symbol_o,
  output logic                     last_o,
  output logic                     invalid_o
);

  logic                       active_q, active_d;
  irn_pkg::irn_entry_t        ent_q, ent_d;
  logic [irn_pkg::PlaceW-1:0] place_q, place_d;
  logic [irn_pkg::StepW-1:0]  k_q, k_d;
  logic                       ovalid_q, ovalid_d;
  logic [irn_pkg::SymW-1:0]   sym_q, sym_d;
  logic                       last_q, last_d;
  logic                       inv_q, inv_d;

  logic                       out_free;
  logic [irn_pkg::PlaceW-1:0] first_place;
  logic [irn_pkg::PlaceW-1:0] next_place;
  logic                       has_lower;
  logic [irn_pkg::DigitW-1:0] cur_digit;
  logic [irn_pkg::LenW-1:0]   cur_len;
  logic                       end_of_place;

  assign out_free      = !ovalid_q || out_ready_i;
  assign entry_ready_o = !active_q;
  assign cur_digit     = ent_q.digits[place_q];
  assign cur_len       = irn_pkg::digit_len(cur_digit);
  assign end_of_place  = ({1'b0, k_q} == cur_len - 1'b1);

  always_comb begin
    first_place = '0;
    for (int i = 0; i < irn_pkg::NumPlaces; i++) begin
      if (entry_i.digits[i] != '0) begin
        first_place = irn_pkg::PlaceW'(i);
      end
    end
  end

  always_comb begin
    next_place = '0;
    has_lower  = 1'b0;
    for (int i = 0; i < irn_pkg::NumPlaces; i++) begin
      if (irn_pkg::PlaceW'(i) < place_q && ent_q.digits[i] != '0) begin
        next_place = irn_pkg::PlaceW'(i);
        has_lower  = 1'b1;
      end
    end
  end

  always_comb begin
    active_d = active_q;
    ent_d    = ent_q;
    place_d  = place_q;
    k_d      = k_q;
    ovalid_d = ovalid_q && !out_ready_i;
    sym_d    = sym_q;
    last_d   = last_q;
    inv_d    = inv_q;
    if (!active_q) begin
      if (entry_valid_i) begin
        active_d = 1'b1;
        ent_d    = entry_i;
        place_d  = first_place;
        k_d      = '0;
      end
    end else if (out_free) begin
      ovalid_d = 1'b1;
      if (ent_q.invalid) begin
        sym_d    = irn_pkg::ChNone;
        last_d   = 1'b1;
        inv_d    = 1'b1;
        active_d = 1'b0;
      end else begin
        sym_d  = irn_pkg::sym_at(place_q, cur_digit, k_q);
        inv_d  = 1'b0;
        last_d = end_of_place && !has_lower;
        if (end_of_place) begin
          if (has_lower) begin
            place_d = next_place;
            k_d     = '0;
          end else begin
            active_d = 1'b0;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    place_q <= place_d;
    k_q     <= k_d;
    sym_q   <= sym_d;
    last_q  <= last_d;
    inv_q   <= inv_d;
  end

  assign out_valid_o = ovalid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;
  assign invalid_o   = inv_q;

endmodule

FILE: rtl/integer_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit binary value to its Roman numeral as a stream of ASCII
// characters.
// ----------------------------------------------------------------------------
// Each input item yields one output item per numeral character, most
// significant place first, with tlast on the final character; a value of
// zero or above 3999 yields a single item with symbol 0, tlast set and tuser
// set. The front part takes a value, runs three compare and subtract
// steps for the decimal places and then hands the digits on. The back
// part emits one character per cycle while the output is not stalled
// and loads the next entry only once it has finished the one before. A
// two-entry queue lets the front convert the next value while the back is
// still emitting.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [irn_pkg::InTdataW-1:0]  s_axis_tdata,   // [11:0] value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [irn_pkg::OutTdataW-1:0] m_axis_tdata,   // [7:0] symbol
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser    // [0] invalid
);

  irn_pkg::irn_entry_t front_entry, back_entry;
  logic                front_valid, front_ready;
  logic                back_valid, back_ready;

  irn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .value_i       (s_axis_tdata[irn_pkg::ValueW-1:0]),
    .entry_valid_o (front_valid),
    .entry_ready_i (front_ready),
    .entry_o       (front_entry)
  );

  irn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_entry),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_entry)
  );

  irn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (back_valid),
    .entry_ready_o (back_ready),
    .entry_i       (back_entry),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .symbol_o      (m_axis_tdata),
    .last_o        (m_axis_tlast),
    .invalid_o     (m_axis_tuser)
  );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the integer to Roman numeral converter.
// ----------------------------------------------------------------------------
// A queue of values, first a directed set and then random ones, feeds a
// stream driver. Each accepted value is converted by a behavioral predictor
// into the expected character items. A monitor compares every output item
// field by field with the oldest expected character. Both sides idle at
// random, apart from one calm stretch, and a watchdog ends the run if nothing
// moves for too long.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumRandom  = 205;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 64;

  typedef struct packed {
    logic [irn_pkg::SymW-1:0] symbol;
    logic                     last;
    logic                     invalid;
  } numeral_char_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [irn_pkg::InTdataW-1:0]  s_axis_tdata = '0;   // [11:0] value
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [irn_pkg::OutTdataW-1:0] m_axis_tdata;        // [7:0] symbol
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;        // [0] invalid

  logic [irn_pkg::ValueW-1:0] value_q[$];
  numeral_char_t              numeral_q[$];
  bit                         value_taken = 1'b0;
  int                         n_values = 0;
  int                         n_chars = 0;
  int                         n_invalid = 0;
  int                         n_errors = 0;
  int                         stall_cycles = 0;

  integer_to_roman_numeral dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Appends the characters of the numeral for one value to the expected queue.
  function automatic void predict_numeral(input logic [irn_pkg::ValueW-1:0] value);
    logic [irn_pkg::SymW-1:0] one_sym  [irn_pkg::NumPlaces] =
      '{irn_pkg::ChI, irn_pkg::ChX, irn_pkg::ChC, irn_pkg::ChM};
    logic [irn_pkg::SymW-1:0] five_sym [irn_pkg::NumPlaces] =
      '{irn_pkg::ChV, irn_pkg::ChL, irn_pkg::ChD, irn_pkg::ChNone};
    logic [irn_pkg::SymW-1:0] ten_sym  [irn_pkg::NumPlaces] =
      '{irn_pkg::ChX, irn_pkg::ChC, irn_pkg::ChM, irn_pkg::ChNone};
    logic [irn_pkg::SymW-1:0] chars[$];
    int                       scale;
    int                       digit;
    if (value == 0 || value > irn_pkg::ValueMax) begin
      numeral_q.push_back('{irn_pkg::ChNone, 1'b1, 1'b1});
      return;
    end
    scale = 1000;
    for (int p = irn_pkg::NumPlaces - 1; p >= 0; p--) begin
      digit = (int'(value) / scale) % 10;
      scale = scale / 10;
      if (digit == 9) begin
        chars.push_back(one_sym[p]);
        chars.push_back(ten_sym[p]);
      end else if (digit == 4) begin
        chars.push_back(one_sym[p]);
        chars.push_back(five_sym[p]);
      end else begin
        if (digit >= 5) begin
          chars.push_back(five_sym[p]);
          digit -= 5;
        end
        for (int k = 0; k < digit; k++) begin
          chars.push_back(one_sym[p]);
        end
      end
    end
    foreach (chars[i]) begin
      numeral_q.push_back('{chars[i], i == chars.size() - 1, 1'b0});
    end
  endfunction

  function automatic bit calm_stretch();
    return n_values >= 120 && n_values < 170;
  endfunction

  // The driver presents a new value once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || value_taken) begin
        if (value_q.size() > 0 && (calm_stretch() || $urandom_range(99) >= 7)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(irn_pkg::InTdataW - irn_pkg::ValueW){1'b0}},
                            value_q.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm_stretch() || $urandom_range(99) >= 7;
    end
    value_taken = 1'b0;
  end

  always @(posedge clk_i) begin
    numeral_char_t want;
    bit            moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_numeral(s_axis_tdata[irn_pkg::ValueW-1:0]);
        value_taken = 1'b1;
        n_values++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        n_chars++;
        if (m_axis_tuser) begin
          n_invalid++;
        end
        if (numeral_q.size() == 0) begin
          $error("unexpected item: symbol %h last %b invalid %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          n_errors++;
        end else begin
          want = numeral_q.pop_front();
          if (m_axis_tdata !== want.symbol) begin
            $error("symbol: expected %h, actual %h", want.symbol, m_axis_tdata);
            n_errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, m_axis_tlast);
            n_errors++;
          end
          if (m_axis_tuser !== want.invalid) begin
            $error("invalid: expected %b, actual %b", want.invalid, m_axis_tuser);
            n_errors++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles", StallLimit);
        $display("integer_to_roman_numeral test failed");
        $finish;
      end
    end
  end

  initial begin
    int directed[$] = '{
      1, 3999, 0, 4000, 4095, 3888, 1994, 4, 9, 40, 90, 400, 900,
      5, 50, 500, 1000, 2048, 1365, 2730, 444, 999, 3000, 8, 2
    };
    foreach (directed[i]) begin
      value_q.push_back(irn_pkg::ValueW'(directed[i]));
    end
    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(19))
        0:       value_q.push_back('0);
        1:       value_q.push_back(irn_pkg::ValueW'($urandom_range(4095,
                                                    irn_pkg::ValueMax + 1)));
        2:       value_q.push_back(irn_pkg::ValueW'($urandom_range(9, 1)));
        default: value_q.push_back(irn_pkg::ValueW'($urandom_range(irn_pkg::ValueMax,
                                                                   1)));
      endcase
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (value_q.size() > 0 || s_axis_tvalid || numeral_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
    $display("Converted %0d values into %0d output items, %0d of them flagged invalid.",
             n_values, n_chars, n_invalid);
    if (n_errors == 0 && numeral_q.size() == 0) begin
      $display("integer_to_roman_numeral test passed");
    end else begin
      $display("%0d mismatches, %0d expected items left over", n_errors, numeral_q.size());
      $display("integer_to_roman_numeral test failed");
    end
    $finish;
  end

endmodule
